/* rtl/core/ssm_pkg.sv */
// Package for the sorted sample store: sizes, sample and count types,
// request and status codes, and the control word broadcast to the cell row.
// No dependencies; every other file of the block refers to it by scoped names.
package ssm_pkg;

  localparam int CAPACITY    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_W-1:0]              count_t;
  typedef logic [IDX_W-1:0]              idx_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Broadcast to every cell of the row in each cycle.
  typedef struct packed {
    logic    cmp_en;
    logic    ins_en;
    logic    rem_en;
    sample_t sample;
  } cell_ctrl_t;

endpackage

/* rtl/core/ssm_req_if.sv */
// Request channel of the sorted sample store: valid/ready plus one request item.
// Depends on ssm_pkg for the request code and sample types.
interface ssm_req_if;
  logic            valid;
  logic            ready;
  ssm_pkg::req_e   req_type;
  ssm_pkg::sample_t sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

/* rtl/core/ssm_res_if.sv */
// Result channel of the sorted sample store: valid/ready plus one result item.
// Depends on ssm_pkg for the status code, count and sample types.
interface ssm_res_if;
  logic              valid;
  logic              ready;
  ssm_pkg::status_e  status;
  ssm_pkg::count_t   count;
  ssm_pkg::sample_t  min_value;
  ssm_pkg::sample_t  max_value;
  ssm_pkg::sample_t  median_value;

  modport source (output valid, output status, output count, output min_value,
                  output max_value, output median_value, input ready);
  modport sink   (input valid, input status, input count, input min_value,
                  input max_value, input median_value, output ready);
endinterface

/* rtl/core/ssm_cell.sv */
// One cell of the sorted row: holds one sample, compares it with the
// broadcast sample and shifts toward either neighbor. Depends on ssm_pkg.
module ssm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssm_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                tail_i,
  input  ssm_pkg::sample_t    left_val_i,
  input  logic                left_gt_i,
  input  ssm_pkg::sample_t    right_val_i,
  input  logic                right_eq_i,
  output ssm_pkg::sample_t    val_o,
  output logic                gt_o,
  output logic                eq_o
);

  ssm_pkg::sample_t val_q, val_d;
  logic             gt_q, gt_d;
  logic             eq_q, eq_d;

  always_comb begin
    gt_d = gt_q;
    eq_d = eq_q;
    if (ctrl_i.cmp_en) begin
      gt_d = occ_i && (val_q > ctrl_i.sample);
      eq_d = occ_i && (val_q == ctrl_i.sample);
    end
  end

  // On insert the row opens a gap at the first larger sample; on remove the
  // last copy of the equal run and everything above it move down by one.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins_en) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_q || tail_i) begin
        val_d = ctrl_i.sample;
      end
    end else if (ctrl_i.rem_en) begin
      if (gt_q || (eq_q && !right_eq_i)) begin
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      gt_q <= gt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign gt_o  = gt_q;
  assign eq_o  = eq_q;

endmodule

/* rtl/core/ssm_stats.sv */
// Statistics stage: picks the minimum, maximum and both middle samples out of
// the cell row and forms the floor mean of the middles. Depends on ssm_pkg.
module ssm_stats (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             hi_pass_i,
  input  ssm_pkg::count_t  count_i,
  input  ssm_pkg::sample_t vals_i [ssm_pkg::CAPACITY],
  output ssm_pkg::sample_t min_o,
  output ssm_pkg::sample_t max_o,
  output ssm_pkg::sample_t med_o
);

  ssm_pkg::sample_t min_q, max_q, lo_q, hi_q;
  ssm_pkg::count_t  last_cnt, mid_cnt;
  ssm_pkg::idx_t    last_idx, mid_idx;
  logic signed [ssm_pkg::SAMPLE_BITS:0] mid_sum;

  // The first pass reads the last cell and the lower middle, the second pass
  // the upper middle, so the row is read at two variable positions at most.
  always_comb begin
    last_cnt = count_i - ssm_pkg::count_t'(1);
    mid_cnt  = hi_pass_i ? (count_i >> 1) : (last_cnt >> 1);
    last_idx = last_cnt[ssm_pkg::IDX_W-1:0];
    mid_idx  = mid_cnt[ssm_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (count_i == '0) begin
        min_q <= '0;
        max_q <= '0;
        lo_q  <= '0;
        hi_q  <= '0;
      end else if (hi_pass_i) begin
        hi_q <= vals_i[mid_idx];
      end else begin
        min_q <= vals_i[0];
        max_q <= vals_i[last_idx];
        lo_q  <= vals_i[mid_idx];
      end
    end
  end

  // With an odd count both middles are the same cell, so one formula serves.
  assign mid_sum = {lo_q[ssm_pkg::SAMPLE_BITS-1], lo_q}
                 + {hi_q[ssm_pkg::SAMPLE_BITS-1], hi_q};
  assign med_o   = mid_sum[ssm_pkg::SAMPLE_BITS:1];
  assign min_o   = min_q;
  assign max_o   = max_q;

endmodule

/* rtl/core/sorted_sample_store_median_core.sv */
// Channel | dir | payload
// req_i   | in  | req_type (insert/remove), sample (signed Q8.8)
// res_o   | out | status, count, min_value, max_value, median_value
//
// Each item passes through six steps: accept, compare in every cell, shift the row,
// read the minimum, maximum and lower middle, read the upper middle, load the
// result register. The compare-then-shift pass through the cell row and the
// two-pass statistics readout set that number of steps.
// A new item is taken while a previous result still waits in the output
// register; the block holds in its last step only until that register frees.
// Reset empties the store at once (count zero); no clearing pass is needed.
// Depends on ssm_pkg, ssm_req_if, ssm_res_if, ssm_cell and ssm_stats.
module sorted_sample_store_median_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssm_req_if.sink   req_i,
  ssm_res_if.source res_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMP  = 6'b000010,
    S_UPD  = 6'b000100,
    S_STAT = 6'b001000,
    S_MID  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  ssm_pkg::req_e    op_q;
  ssm_pkg::sample_t smp_q;
  ssm_pkg::count_t  count_q, count_d;
  ssm_pkg::status_e status_q, status_d;
  logic             load_req;
  logic             stat_en;
  logic             stat_hi;
  logic             res_load;
  logic             res_valid_q, res_valid_d;

  ssm_pkg::status_e res_status_q;
  ssm_pkg::count_t  res_count_q;
  ssm_pkg::sample_t res_min_q, res_max_q, res_med_q;

  ssm_pkg::cell_ctrl_t ctrl;
  ssm_pkg::sample_t    cell_val [ssm_pkg::CAPACITY];
  logic [ssm_pkg::CAPACITY-1:0] cell_gt;
  logic [ssm_pkg::CAPACITY-1:0] cell_eq;
  logic                         found;

  ssm_pkg::sample_t stat_min, stat_max, stat_med;

  assign found = |cell_eq;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    load_req    = 1'b0;
    stat_en     = 1'b0;
    stat_hi     = 1'b0;
    res_load    = 1'b0;
    res_valid_d = res_valid_q && !res_o.ready;
    ctrl.cmp_en = 1'b0;
    ctrl.ins_en = 1'b0;
    ctrl.rem_en = 1'b0;
    ctrl.sample = smp_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          load_req = 1'b1;
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = S_UPD;
      end
      S_UPD: begin
        status_d = ssm_pkg::ST_DONE;
        if (op_q == ssm_pkg::OP_INSERT) begin
          if (count_q == ssm_pkg::count_t'(ssm_pkg::CAPACITY)) begin
            status_d = ssm_pkg::ST_FULL;
          end else begin
            ctrl.ins_en = 1'b1;
            count_d     = count_q + ssm_pkg::count_t'(1);
          end
        end else if (found) begin
          ctrl.rem_en = 1'b1;
          count_d     = count_q - ssm_pkg::count_t'(1);
        end else begin
          status_d = ssm_pkg::ST_NOT_FOUND;
        end
        state_d = S_STAT;
      end
      S_STAT: begin
        stat_en = 1'b1;
        state_d = S_MID;
      end
      S_MID: begin
        stat_en = 1'b1;
        stat_hi = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!res_valid_q || res_o.ready) begin
          res_load    = 1'b1;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (load_req) begin
      op_q  <= req_i.req_type;
      smp_q <= req_i.sample;
    end
    if (res_load) begin
      res_status_q <= status_q;
      res_count_q  <= count_q;
      res_min_q    <= stat_min;
      res_max_q    <= stat_max;
      res_med_q    <= stat_med;
    end
  end

  for (genvar k = 0; k < ssm_pkg::CAPACITY; k++) begin : g_cell
    ssm_pkg::sample_t left_val, right_val;
    logic             left_gt, right_eq;

    if (k == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid_l
      assign left_val = cell_val[k-1];
      assign left_gt  = cell_gt[k-1];
    end

    if (k == ssm_pkg::CAPACITY - 1) begin : g_last
      assign right_val = '0;
      assign right_eq  = 1'b0;
    end else begin : g_mid_r
      assign right_val = cell_val[k+1];
      assign right_eq  = cell_eq[k+1];
    end

    ssm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .occ_i       (ssm_pkg::count_t'(k) < count_q),
      .tail_i      (ssm_pkg::count_t'(k) == count_q),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .right_eq_i  (right_eq),
      .val_o       (cell_val[k]),
      .gt_o        (cell_gt[k]),
      .eq_o        (cell_eq[k])
    );
  end

  ssm_stats u_stats (
    .clk_i     (clk_i),
    .en_i      (stat_en),
    .hi_pass_i (stat_hi),
    .count_i   (count_q),
    .vals_i    (cell_val),
    .min_o     (stat_min),
    .max_o     (stat_max),
    .med_o     (stat_med)
  );

  assign req_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_status_q;
  assign res_o.count        = res_count_q;
  assign res_o.min_value    = res_min_q;
  assign res_o.max_value    = res_max_q;
  assign res_o.median_value = res_med_q;

endmodule

/* bench/sorted_sample_store_median_core_tb.sv */
// Testbench for the sorted sample store with running min, max and median.
// Needs ssm_pkg, ssm_req_if, ssm_res_if and sorted_sample_store_median_core.
// A directed table runs first, then random insert/remove traffic is checked.
module sorted_sample_store_median_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int DIR_N          = 21;

  typedef struct packed {
    ssm_pkg::status_e status;
    ssm_pkg::count_t  count;
    ssm_pkg::sample_t min_value;
    ssm_pkg::sample_t max_value;
    ssm_pkg::sample_t median_value;
  } stats_t;

  typedef struct packed {
    ssm_pkg::req_e    op;
    ssm_pkg::sample_t sample;
    logic             fixed;
    stats_t           want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ssm_req_if req_if ();
  ssm_res_if res_if ();

  sorted_sample_store_median_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Rows with fixed set carry a result that is obvious by hand.
  dir_row_t dir_rows [DIR_N] = '{
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(0), 1'b1,
      '{ssm_pkg::ST_NOT_FOUND, ssm_pkg::count_t'(0), ssm_pkg::sample_t'(0),
        ssm_pkg::sample_t'(0), ssm_pkg::sample_t'(0)}},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(32767), 1'b1,
      '{ssm_pkg::ST_DONE, ssm_pkg::count_t'(1), ssm_pkg::sample_t'(32767),
        ssm_pkg::sample_t'(32767), ssm_pkg::sample_t'(32767)}},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(-32768), 1'b1,
      '{ssm_pkg::ST_DONE, ssm_pkg::count_t'(2), ssm_pkg::sample_t'(-32768),
        ssm_pkg::sample_t'(32767), ssm_pkg::sample_t'(-1)}},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(0),      1'b0, '0},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(0),      1'b0, '0},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(256),    1'b0, '0},
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(0),      1'b0, '0},
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(5),      1'b0, '0},
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(32767),  1'b0, '0},
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(-32768), 1'b0, '0},
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(0),      1'b0, '0},
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(256), 1'b1,
      '{ssm_pkg::ST_DONE, ssm_pkg::count_t'(0), ssm_pkg::sample_t'(0),
        ssm_pkg::sample_t'(0), ssm_pkg::sample_t'(0)}},
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(256), 1'b1,
      '{ssm_pkg::ST_NOT_FOUND, ssm_pkg::count_t'(0), ssm_pkg::sample_t'(0),
        ssm_pkg::sample_t'(0), ssm_pkg::sample_t'(0)}},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(-1), 1'b1,
      '{ssm_pkg::ST_DONE, ssm_pkg::count_t'(1), ssm_pkg::sample_t'(-1),
        ssm_pkg::sample_t'(-1), ssm_pkg::sample_t'(-1)}},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(-2), 1'b1,
      '{ssm_pkg::ST_DONE, ssm_pkg::count_t'(2), ssm_pkg::sample_t'(-2),
        ssm_pkg::sample_t'(-1), ssm_pkg::sample_t'(-2)}},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(-32768), 1'b0, '0},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(-32768), 1'b0, '0},
    '{ssm_pkg::OP_REMOVE, ssm_pkg::sample_t'(-32768), 1'b0, '0},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(32767),  1'b0, '0},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(-21846), 1'b0, '0},
    '{ssm_pkg::OP_INSERT, ssm_pkg::sample_t'(21845),  1'b0, '0}
  };

  // Shadow copy of the store, updated as each request item is accepted.
  ssm_pkg::sample_t shadow_store [ssm_pkg::CAPACITY];
  int               shadow_fill;

  stats_t  pending_stats [$];
  logic    cur_fixed;
  stats_t  cur_want;
  logic    idle_on;
  int      stall_left;
  int      quiet_cycles;
  int      mismatch_count;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic stats_t apply_request(ssm_pkg::req_e op, ssm_pkg::sample_t s);
    stats_t r;
    int pos;
    logic signed [ssm_pkg::SAMPLE_BITS:0] mid_sum;
    r.status = ssm_pkg::ST_DONE;
    if (op == ssm_pkg::OP_INSERT) begin
      if (shadow_fill >= ssm_pkg::CAPACITY) begin
        r.status = ssm_pkg::ST_FULL;
      end else begin
        pos = shadow_fill;
        for (int k = 0; k < shadow_fill; k++) begin
          if (shadow_store[k] > s) begin
            pos = k;
            break;
          end
        end
        for (int k = shadow_fill; k > pos; k--) shadow_store[k] = shadow_store[k-1];
        shadow_store[pos] = s;
        shadow_fill++;
      end
    end else begin
      pos = -1;
      for (int k = 0; k < shadow_fill; k++) begin
        if (shadow_store[k] == s) begin
          pos = k;
          break;
        end
      end
      if (pos < 0) begin
        r.status = ssm_pkg::ST_NOT_FOUND;
      end else begin
        for (int k = pos; k + 1 < shadow_fill; k++) shadow_store[k] = shadow_store[k+1];
        shadow_fill--;
      end
    end
    r.count = ssm_pkg::count_t'(shadow_fill);
    if (shadow_fill == 0) begin
      r.min_value    = '0;
      r.max_value    = '0;
      r.median_value = '0;
    end else begin
      r.min_value = shadow_store[0];
      r.max_value = shadow_store[shadow_fill-1];
      if (shadow_fill % 2 == 1) begin
        r.median_value = shadow_store[shadow_fill/2];
      end else begin
        // The arithmetic shift floors the mean toward minus infinity.
        mid_sum = shadow_store[(shadow_fill-1)/2] + shadow_store[shadow_fill/2];
        r.median_value = ssm_pkg::sample_t'(mid_sum >>> 1);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    stats_t exp_r;
    stats_t pred_r;
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (res_if.valid && res_if.ready) begin
        if (pending_stats.size() == 0) begin
          report_mismatch("result item with no request waiting", int'(res_if.count), -1);
        end else begin
          exp_r = pending_stats.pop_front();
          if (res_if.status !== exp_r.status)
            report_mismatch("status", int'(res_if.status), int'(exp_r.status));
          if (res_if.count !== exp_r.count)
            report_mismatch("count", int'(res_if.count), int'(exp_r.count));
          if (res_if.min_value !== exp_r.min_value)
            report_mismatch("min_value", int'(res_if.min_value), int'(exp_r.min_value));
          if (res_if.max_value !== exp_r.max_value)
            report_mismatch("max_value", int'(res_if.max_value), int'(exp_r.max_value));
          if (res_if.median_value !== exp_r.median_value)
            report_mismatch("median_value", int'(res_if.median_value),
                            int'(exp_r.median_value));
        end
      end
      if (req_if.valid && req_if.ready) begin
        pred_r = apply_request(req_if.req_type, req_if.sample);
        pending_stats = {pending_stats, (cur_fixed ? cur_want : pred_r)};
      end
    end
  end

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin
    res_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(1, 9) - 1;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic drive_request(ssm_pkg::req_e op, ssm_pkg::sample_t s, logic fixed,
                               stats_t want);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.req_type = op;
    req_if.sample   = s;
    cur_fixed       = fixed;
    cur_want        = want;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Mixes full-range values, a small pool that produces duplicates, and extremes.
  function automatic ssm_pkg::sample_t pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return ssm_pkg::sample_t'($urandom_range(0, 65535));
    if (sel < 9) return ssm_pkg::sample_t'($signed($urandom_range(0, 15)) - 8);
    return $urandom_range(0, 1) ? ssm_pkg::sample_t'(32767) : ssm_pkg::sample_t'(-32768);
  endfunction

  task automatic random_phase(int n_items, int insert_pct);
    ssm_pkg::req_e    op;
    ssm_pkg::sample_t s;
    for (int i = 0; i < n_items; i++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? ssm_pkg::OP_INSERT : ssm_pkg::OP_REMOVE;
      // Most removes target a stored value so the store actually drains.
      if (op == ssm_pkg::OP_REMOVE && shadow_fill > 0 && $urandom_range(0, 9) < 8)
        s = shadow_store[$urandom_range(0, shadow_fill - 1)];
      else
        s = pick_sample();
      drive_request(op, s, 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = ssm_pkg::OP_INSERT;
    req_if.sample   = '0;
    cur_fixed       = 1'b0;
    cur_want        = '0;
    idle_on         = 1'b1;
    quiet_cycles    = 0;
    mismatch_count  = 0;
    shadow_fill     = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      drive_request(dir_rows[i].op, dir_rows[i].sample, dir_rows[i].fixed, dir_rows[i].want);

    // Fill past capacity, drain mostly, then mixed traffic at full rate.
    random_phase(290, 95);
    random_phase(150, 15);
    idle_on = 1'b0;
    random_phase(80, 50);
    req_if.valid = 1'b0;

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_stats.size() != 0)
      report_mismatch("requests left without result", pending_stats.size(), 0);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
